// File: design/linear_probe_hash_table_core_macros.svh
// Assertion macros for the linear probe hash table core.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lpht_pkg.sv
// Shared types and constants for the linear probe hash table core.
// No dependencies; every design module imports this package.
package lpht_pkg;

    localparam int TABLE_SIZE = 512;
    localparam int KEY_W      = 30;
    localparam int SLOT_W     = 9;
    localparam int PROBE_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;

    localparam logic [PROBE_W-1:0] PROBE_FULL = PROBE_W'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TABLE_SIZE - 1);

    // Operation kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Hash mode codes; the unused code behaves as division.
    localparam logic [MODE_W-1:0] MODE_DIV  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOLD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MID  = 2'd2;

    // Serial divide-by-constant unit.
    localparam int DIVN_W     = 60;
    localparam int REM_W      = 24;
    localparam int RADIX_BITS = 4;
    localparam int DIVS_W     = 4;
    localparam logic [REM_W-1:0] DIV_SMALL = 24'd1000;
    localparam logic [REM_W-1:0] DIV_BIG   = 24'd10000000;

    // Folding works on a 32-bit window at the top of the dividend.
    localparam int FOLD_SHIFT = DIVN_W - 32;
    localparam logic [DIVS_W-1:0] FOLD_STEPS = 4'd8;
    // Mid-square: full 60-bit square, then a 40-bit quotient window.
    localparam int MID_SHIFT = DIVN_W - 40;
    localparam logic [DIVS_W-1:0] MID_STEPS_SQ  = 4'd15;
    localparam logic [DIVS_W-1:0] MID_STEPS_MOD = 4'd10;

    // Request queue between the hashing front and the probing back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
    } lpht_req_t;

endpackage

// File: design/lpht_divc.sv
// Serial divider by a fixed constant (1000 or 10^7), four quotient bits per cycle.
// Depends on lpht_pkg.
module lpht_divc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lpht_pkg::DIVN_W-1:0] dividend,
    input  logic [lpht_pkg::DIVS_W-1:0] steps,
    input  logic                        big,
    output logic                        done,
    output logic [lpht_pkg::DIVN_W-1:0] quotient,
    output logic [lpht_pkg::REM_W-1:0]  remainder
);
    import lpht_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVS_W-1:0]     cnt_reg, cnt_next;
    logic [DIVN_W-1:0]     num_reg;
    logic [DIVN_W-1:0]     quo_reg;
    logic [REM_W-1:0]      rem_reg;
    logic                  big_reg;
    logic [REM_W-1:0]      dval;
    logic [REM_W-1:0]      rem_step;
    logic [REM_W:0]        trial;
    logic [RADIX_BITS-1:0] qbits;

    // Restoring division, one bit per inner iteration.
    always_comb begin
        dval     = big_reg ? DIV_BIG : DIV_SMALL;
        rem_step = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < RADIX_BITS; i++) begin
            trial = {rem_step, num_reg[DIVN_W-1-i]};
            if (trial >= {1'b0, dval}) begin
                rem_step = REM_W'(trial - {1'b0, dval});
                qbits[RADIX_BITS-1-i] = 1'b1;
            end else begin
                rem_step = trial[REM_W-1:0];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIVS_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= '0;
            big_reg <= big;
        end else if (busy_reg) begin
            num_reg <= num_reg << RADIX_BITS;
            quo_reg <= {quo_reg[DIVN_W-RADIX_BITS-1:0], qbits};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: design/lpht_fifo.sv
// Short request queue between the hashing front and the probing back.
// Depends on lpht_pkg.
module lpht_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lpht_pkg::lpht_req_t   push_data,
    output logic                  full,
    input  logic                  pop,
    output lpht_pkg::lpht_req_t   pop_data,
    output logic                  empty
);
    import lpht_pkg::*;

    lpht_req_t          entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entries[rd_ptr_reg];

endmodule

// File: design/lpht_front.sv
// Front end: accepts operations, computes the home slot, queues the request.
// Depends on lpht_pkg and lpht_divc.
module lpht_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lpht_pkg::MODE_W-1:0] hash_mode,
    input  logic                        clr_busy,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [lpht_pkg::KEY_W-1:0]  s_key,
    output logic                        q_push,
    output lpht_pkg::lpht_req_t         q_data,
    input  logic                        q_full
);
    import lpht_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_FOLD = 3'd1;
    localparam logic [2:0] F_MID1 = 3'd2;
    localparam logic [2:0] F_MID2 = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        grp_reg, grp_next;
    logic              kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [SLOT_W-1:0] sum_reg, sum_next;
    logic [SLOT_W-1:0] sum_add;
    logic              accept;

    logic              div_start;
    logic [DIVN_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_steps;
    logic              div_big;
    logic              div_done;
    logic [DIVN_W-1:0] div_quo;
    logic [REM_W-1:0]  div_rem;
    logic [DIVN_W-1:0] key_ext;
    logic [DIVN_W-1:0] key_sq;

    lpht_divc u_divc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .steps     (div_steps),
        .big       (div_big),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready = (state_reg == F_IDLE) && !clr_busy;
    assign accept  = s_valid && s_ready;
    assign key_ext = DIVN_W'(s_key);
    assign key_sq  = key_ext * key_ext;
    assign sum_add = sum_reg + div_rem[SLOT_W-1:0];

    always_comb begin
        state_next   = state_reg;
        grp_next     = grp_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        home_next    = home_reg;
        sum_next     = sum_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_steps    = FOLD_STEPS;
        div_big      = 1'b0;
        q_push       = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    kind_next = s_kind;
                    key_next  = s_key;
                    sum_next  = '0;
                    grp_next  = '0;
                    case (hash_mode)
                        MODE_FOLD: begin
                            div_start    = 1'b1;
                            div_dividend = key_ext << FOLD_SHIFT;
                            div_steps    = FOLD_STEPS;
                            state_next   = F_FOLD;
                        end
                        MODE_MID: begin
                            div_start    = 1'b1;
                            div_dividend = key_sq;
                            div_steps    = MID_STEPS_SQ;
                            div_big      = 1'b1;
                            state_next   = F_MID1;
                        end
                        default: begin
                            home_next  = s_key[SLOT_W-1:0];
                            state_next = F_PUSH;
                        end
                    endcase
                end
            end
            F_FOLD: begin
                if (div_done) begin
                    if (grp_reg == 2'd2) begin
                        // The last quotient is the top group, at most 1.
                        home_next  = sum_add + div_quo[SLOT_W-1:0];
                        state_next = F_PUSH;
                    end else begin
                        sum_next     = sum_add;
                        grp_next     = grp_reg + 1'b1;
                        div_start    = 1'b1;
                        div_dividend = DIVN_W'(div_quo[31:0]) << FOLD_SHIFT;
                        div_steps    = FOLD_STEPS;
                    end
                end
            end
            F_MID1: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = DIVN_W'(div_quo[39:0]) << MID_SHIFT;
                    div_steps    = MID_STEPS_MOD;
                    state_next   = F_MID2;
                end
            end
            F_MID2: begin
                if (div_done) begin
                    home_next  = div_rem[SLOT_W-1:0];
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                q_push = !q_full;
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            grp_reg   <= '0;
        end else begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        key_reg  <= key_next;
        home_reg <= home_next;
        sum_reg  <= sum_next;
    end

    assign q_data.kind = kind_reg;
    assign q_data.key  = key_reg;
    assign q_data.home = home_reg;

endmodule

// File: design/lpht_back.sv
// Back end: slot memory, clearing pass, probe sequencer and result register.
// Depends on lpht_pkg.
module lpht_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          clr_busy,
    output logic                          q_pop,
    input  lpht_pkg::lpht_req_t           q_data,
    input  logic                          q_empty,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpht_pkg::STATUS_W-1:0] m_status,
    output logic [lpht_pkg::SLOT_W-1:0]   m_slot,
    output logic [lpht_pkg::PROBE_W-1:0]  m_probe_count
);
    import lpht_pkg::*;

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_CHECK = 2'd2;

    // Each word holds the used flag above the key.
    logic [KEY_W:0]      mem [TABLE_SIZE];
    logic [KEY_W:0]      rd_q;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [KEY_W:0]      wr_data;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [PROBE_W-1:0]  cnt_reg, cnt_next;
    logic                kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [PROBE_W-1:0]  out_cnt_reg, out_cnt_next;

    logic                used, match, last, out_free;
    logic                fin, store;
    logic [STATUS_W-1:0] fin_status;
    logic [SLOT_W-1:0]   fin_slot;

    assign used     = rd_q[KEY_W];
    assign match    = (rd_q[KEY_W-1:0] == key_reg);
    assign last     = (cnt_reg == PROBE_FULL);
    assign out_free = !out_valid_reg || m_ready;
    assign clr_busy = (state_reg == B_CLEAR);

    // Outcome of the slot whose contents sit in rd_q.
    always_comb begin
        fin        = 1'b0;
        store      = 1'b0;
        fin_status = ST_NOT_FOUND;
        fin_slot   = '0;
        if (!used) begin
            fin = 1'b1;
            if (kind_reg == KIND_INSERT) begin
                store      = 1'b1;
                fin_status = ST_INSERTED;
                fin_slot   = pos_reg;
            end
        end else if (kind_reg == KIND_SEARCH && match) begin
            fin        = 1'b1;
            fin_status = ST_FOUND;
            fin_slot   = pos_reg;
        end else if (last) begin
            fin        = 1'b1;
            fin_status = (kind_reg == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_cnt_next    = out_cnt_reg;
        rd_addr         = pos_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = {1'b1, key_reg};
        q_pop           = 1'b0;
        case (state_reg)
            B_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_LAST) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    rd_addr    = q_data.home;
                    pos_next   = q_data.home;
                    cnt_next   = PROBE_W'(1);
                    kind_next  = q_data.kind;
                    key_next   = q_data.key;
                    state_next = B_CHECK;
                end
            end
            B_CHECK: begin
                if (fin) begin
                    // Hold on the same slot until the result register frees up.
                    if (out_free) begin
                        wr_en           = store;
                        out_valid_next  = 1'b1;
                        out_status_next = fin_status;
                        out_slot_next   = fin_slot;
                        out_cnt_next    = cnt_reg;
                        state_next      = B_IDLE;
                    end
                end else begin
                    pos_next = pos_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    rd_addr  = pos_reg + 1'b1;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_slot        = out_slot_reg;
    assign m_probe_count = out_cnt_reg;

endmodule

// File: design/linear_probe_hash_table_core.sv
// Linear probe hash table core: top level with hash mode register and assertions.
// Depends on lpht_pkg, lpht_front, lpht_fifo, lpht_back and the macros header.
//
// Usage. The s_ channel carries one operation per beat: s_kind selects insert or
// search and s_key is the 30-bit key. The m_ channel returns one beat per operation
// with m_status, m_slot and m_probe_count, in the order the operations arrived.
// cfg_wr_en/cfg_wr_data write the hash mode (division, folding, mid-square) and
// should only change while no operation is in flight.
// Hashing. The front hashes one key at a time: division mode uses the low key bits,
// folding mode runs three serial divisions by 1000 and mid-square mode a division
// by 10^7 and one by 1000; the shared divider yields four quotient bits per cycle.
// A four-entry queue feeds the back, whose single memory read port examines one
// slot per cycle unless a finished result waits for the output register.
// Reset. After reset the back runs a clearing pass over all 512 slots, one per
// cycle; s_ready stays low until it ends. The hash mode resets to division.
// Stalls. While m_ready is low the finished result waits in the output register;
// the back holds its next result, the queue fills and the front stalls, s_ready low.
`include "linear_probe_hash_table_core_macros.svh"

module linear_probe_hash_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lpht_pkg::MODE_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpht_pkg::STATUS_W-1:0] m_status,
    output logic [lpht_pkg::SLOT_W-1:0]   m_slot,
    output logic [lpht_pkg::PROBE_W-1:0]  m_probe_count
);
    import lpht_pkg::*;

    logic [MODE_W-1:0] hash_mode_reg, hash_mode_next;
    logic              clr_busy;
    logic              q_push, q_full, q_pop, q_empty;
    lpht_req_t         q_in, q_out;

    // Takes every write; the user must keep the block idle when the mode changes.
    assign hash_mode_next = cfg_wr_en ? cfg_wr_data : hash_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_mode_reg <= MODE_DIV;
        end else begin
            hash_mode_reg <= hash_mode_next;
        end
    end

    // Front: takes beats, computes the home slot and pushes a request.
    lpht_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hash_mode (hash_mode_reg),
        .clr_busy  (clr_busy),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_key     (s_key),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    // Queue lets hashing run ahead of probing.
    lpht_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back: probes the slot memory and holds the result beat.
    lpht_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clr_busy      (clr_busy),
        .q_pop         (q_pop),
        .q_data        (q_out),
        .q_empty       (q_empty),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_probe_count (m_probe_count)
    );

    // No beat may enter while the clearing pass is still sweeping the memory.
    `LPHT_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !s_ready, "beat accepted during clear")
    // The front only pushes into a queue with room.
    `LPHT_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full, "push into full queue")
    // A full table is reported only after every slot was probed.
    `LPHT_ASSERT_NOW(a_full_result, m_valid && (m_status == ST_FULL),
        (m_probe_count == PROBE_FULL) && (m_slot == '0), "bad table full result")
    // A pop always starts a probe sequence in the following cycle.
    `LPHT_ASSERT_NEXT(a_pop_starts_probe, q_pop, !q_pop && !clr_busy, "pop not followed by probe")

endmodule

// File: tb/linear_probe_hash_table_core_test.sv
// Self-checking testbench for linear_probe_hash_table_core: inserts, searches, hash modes,
// collisions, wraparound and a full table, under random idling on both channels.
// Depends on lpht_pkg and the core RTL; needs no files or arguments.
module linear_probe_hash_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    // The fourth hash mode code has no name in the package; it behaves as division.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Every differing field of a result beat counts; only the first few are printed.
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PROBE_W-1:0]  probes;
    } table_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [MODE_W-1:0]     cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_kind      = 1'b0;
    logic [KEY_W-1:0]      s_key       = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_W-1:0]     m_slot;
    logic [PROBE_W-1:0]    m_probe_count;

    // Shadow copy of the table: the keys, the occupancy map and the hash mode register.
    // Key contents of a slot are only ever looked at when its occupancy bit is set.
    logic [KEY_W-1:0]      shadow_keys [TABLE_SIZE];
    logic                  shadow_used [TABLE_SIZE];
    logic [MODE_W-1:0]     shadow_mode = MODE_DIV;
    int                    slots_filled = 0;

    // Results still owed by the block, oldest first, and the keys stored so far.
    table_result_t         expected_results [$];
    logic [KEY_W-1:0]      known_keys [$];
    table_result_t         head_result;

    int                    mismatches = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    linear_probe_hash_table_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_probe_count (m_probe_count)
    );

    // 4 ns clock: two ns high, two ns low.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // The receiver decides once per cycle, at the falling edge, whether it stalls.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Home slot of a key under the current shadow hash mode. Folding adds up the
    // three-digit decimal groups; mid-square keeps digits 8 to 10 of the square.
    function automatic logic [SLOT_W-1:0] home_slot_of(input logic [KEY_W-1:0] key);
        logic [63:0] h;
        logic [63:0] rest;
        logic [63:0] square;
        case (shadow_mode)
            MODE_FOLD: begin
                h = 0;
                rest = 64'(key);
                while (rest != 0) begin
                    h = h + rest % 1000;
                    rest = rest / 1000;
                end
            end
            MODE_MID: begin
                square = 64'(key) * 64'(key);
                h = (square / 10000000) % 1000;
            end
            default: h = 64'(key);
        endcase
        return SLOT_W'(h % TABLE_SIZE);
    endfunction

    // Applies one operation to the shadow table and returns the result beat it must
    // produce. An insert takes the first free slot from home onward; a search stops on
    // a match, on an empty slot, or after it has looked at every slot.
    function automatic table_result_t run_table_op(input logic kind,
                                                   input logic [KEY_W-1:0] key);
        table_result_t res;
        int            pos;
        int            probes;
        bit            done;
        pos = int'(home_slot_of(key));
        probes = 0;
        done = 1'b0;
        res.slot = '0;
        res.status = (kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
        while (probes < TABLE_SIZE && !done) begin
            probes++;
            if (!shadow_used[pos]) begin
                done = 1'b1;
                if (kind == KIND_INSERT) begin
                    shadow_used[pos] = 1'b1;
                    shadow_keys[pos] = key;
                    slots_filled++;
                    res.status = ST_INSERTED;
                    res.slot = SLOT_W'(pos);
                end
            end else if (kind == KIND_SEARCH && shadow_keys[pos] == key) begin
                done = 1'b1;
                res.status = ST_FOUND;
                res.slot = SLOT_W'(pos);
            end else begin
                pos = (pos + 1) % TABLE_SIZE;
            end
        end
        res.probes = PROBE_W'(probes);
        return res;
    endfunction

    // Random key: anywhere in the 30-bit range (above the decimal range too), within
    // nine digits, very small, or sharing a division home slot with a stored key.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = KEY_W'($urandom());
            1: k = KEY_W'($urandom_range(999999999));
            2: k = KEY_W'($urandom_range(4095));
            default: begin
                if (known_keys.size() == 0) begin
                    k = KEY_W'($urandom());
                end else begin
                    k = known_keys[$urandom_range(known_keys.size() - 1)]
                        + KEY_W'(TABLE_SIZE * $urandom_range(1, 8));
                end
            end
        endcase
        return k;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Result checker: every accepted result beat is matched against the oldest
    // outstanding expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_CAP) begin
                    $display("%0t ns: result beat expected none, got status %0d slot %0d",
                             $time, m_status, m_slot);
                end
            end else begin
                head_result = expected_results.pop_front();
                if (m_status !== head_result.status) begin
                    report_mismatch("m_status", head_result.status, m_status);
                end
                if (m_slot !== head_result.slot) begin
                    report_mismatch("m_slot", head_result.slot, m_slot);
                end
                if (m_probe_count !== head_result.probes) begin
                    report_mismatch("m_probe_count", head_result.probes, m_probe_count);
                end
            end
        end
    end

    // All driving tasks start and end at a falling edge. A sent beat keeps s_valid
    // high into the next falling edge, where the next call either reuses it or drops it.
    task automatic send_op(input logic kind, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(run_table_op(kind, key));
        @(negedge aclk);
    endtask

    // Holds the sender off until every outstanding result beat has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // The hash mode only changes while nothing is in flight.
    task automatic write_hash_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        shadow_mode = mode;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Division mode straight out of reset: collisions, a duplicate insert, a search
    // that stops at an empty slot, the largest key, and a probe run that wraps from
    // the last slot back to slot 0.
    task automatic test_division_collisions();
        set_idling(0, 0);
        send_op(KIND_INSERT, 30'd0);
        send_op(KIND_INSERT, 30'd512);
        send_op(KIND_INSERT, 30'd0);
        send_op(KIND_SEARCH, 30'd512);
        send_op(KIND_SEARCH, 30'd1024);
        send_op(KIND_SEARCH, 30'd0);
        send_op(KIND_INSERT, 30'h3FFF_FFFF);
        send_op(KIND_INSERT, 30'd1023);
        send_op(KIND_SEARCH, 30'd1023);
    endtask

    // Folding, mid-square and the spare code on the largest keys and on keys with
    // alternating bit patterns.
    task automatic test_hash_modes();
        write_hash_mode(MODE_FOLD);
        send_op(KIND_INSERT, 30'd999999999);
        send_op(KIND_INSERT, 30'h3FFF_FFFF);
        send_op(KIND_SEARCH, 30'd999999999);
        send_op(KIND_SEARCH, 30'h2AAA_AAAA);
        write_hash_mode(MODE_MID);
        send_op(KIND_INSERT, 30'd999999999);
        send_op(KIND_INSERT, 30'h3FFF_FFFF);
        send_op(KIND_SEARCH, 30'h3FFF_FFFF);
        send_op(KIND_SEARCH, 30'h1555_5555);
        write_hash_mode(MODE_SPARE);
        send_op(KIND_INSERT, 30'h155);
        send_op(KIND_SEARCH, 30'h155);
    endtask

    // Mixed traffic in eight phases; each phase has its own hash mode and idling
    // profile, and the sender drains the block before each mode change. Most searches
    // look for stored keys so that hits on long probe runs are common. Inserts stop
    // well short of a full table, which has a test of its own.
    task automatic test_random_traffic();
        int               dice;
        logic [KEY_W-1:0] key;
        logic [MODE_W-1:0] mode;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: mode = MODE_MID;
                1: mode = MODE_FOLD;
                2: mode = MODE_DIV;
                default: mode = MODE_SPARE;
            endcase
            write_hash_mode(mode);
            case ((phase + phase / 4) % 4)
                0: set_idling(0, 0);
                1: set_idling(59, 0);
                2: set_idling(0, 59);
                default: set_idling(12, 12);
            endcase
            for (int i = 0; i < 135; i++) begin
                dice = $urandom_range(99);
                if (dice < 25 && slots_filled < 400) begin
                    if (dice < 5 && known_keys.size() != 0) begin
                        key = known_keys[$urandom_range(known_keys.size() - 1)];
                    end else begin
                        key = pick_key();
                    end
                    known_keys.push_back(key);
                    send_op(KIND_INSERT, key);
                end else if (dice < 70 && known_keys.size() != 0) begin
                    send_op(KIND_SEARCH, known_keys[$urandom_range(known_keys.size() - 1)]);
                end else begin
                    send_op(KIND_SEARCH, pick_key());
                end
            end
        end
    endtask

    // Fills every free slot with a key whose division home is that slot, then checks
    // inserts that find no room and searches that scan the whole table.
    task automatic test_full_table();
        write_hash_mode(MODE_DIV);
        set_idling(12, 12);
        for (int j = 0; j < TABLE_SIZE; j++) begin
            if (!shadow_used[j]) begin
                send_op(KIND_INSERT, {21'($urandom()), SLOT_W'(j)});
            end
        end
        send_op(KIND_INSERT, pick_key());
        send_op(KIND_SEARCH, 30'h2AAA_AAAA);
        send_op(KIND_SEARCH, shadow_keys[$urandom_range(TABLE_SIZE - 1)]);
        write_hash_mode(MODE_FOLD);
        send_op(KIND_INSERT, 30'd999999999);
        send_op(KIND_SEARCH, 30'h1555_5555);
        write_hash_mode(MODE_SPARE);
        send_op(KIND_SEARCH, shadow_keys[0]);
    endtask

    initial begin
        for (int j = 0; j < TABLE_SIZE; j++) begin
            shadow_used[j] = 1'b0;
            shadow_keys[j] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The block clears its slot map after reset; the first beat
        // simply waits for s_ready.
        test_division_collisions();
        test_hash_modes();
        test_random_traffic();
        test_full_table();

        drain_results();
        // Leave room for any stray result beat to show up before the verdict.
        repeat (32) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[linear_probe_hash_table_core] OK");
        end else begin
            $display("[linear_probe_hash_table_core] ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("[linear_probe_hash_table_core] ERROR");
        $finish;
    end

endmodule
